@@ sv/mseu_pkg.sv @@
// ----------------------------------------------------------------------------
// mseu_pkg
// Shared codes and types of the SPECIAL-class execute unit.
// ----------------------------------------------------------------------------
package mseu_pkg;

    // Funct codes
    localparam logic [5:0] F_SLL     = 6'h00;
    localparam logic [5:0] F_SRL     = 6'h02;
    localparam logic [5:0] F_SRA     = 6'h03;
    localparam logic [5:0] F_SLLV    = 6'h04;
    localparam logic [5:0] F_SRLV    = 6'h06;
    localparam logic [5:0] F_SRAV    = 6'h07;
    localparam logic [5:0] F_JR      = 6'h08;
    localparam logic [5:0] F_JALR    = 6'h09;
    localparam logic [5:0] F_SYSCALL = 6'h0C;
    localparam logic [5:0] F_BREAK   = 6'h0D;
    localparam logic [5:0] F_SYNC    = 6'h0F;
    localparam logic [5:0] F_MFHI    = 6'h10;
    localparam logic [5:0] F_MTHI    = 6'h11;
    localparam logic [5:0] F_MFLO    = 6'h12;
    localparam logic [5:0] F_MTLO    = 6'h13;
    localparam logic [5:0] F_DSLLV   = 6'h14;
    localparam logic [5:0] F_DSRLV   = 6'h16;
    localparam logic [5:0] F_DSRAV   = 6'h17;
    localparam logic [5:0] F_MULT    = 6'h18;
    localparam logic [5:0] F_MULTU   = 6'h19;
    localparam logic [5:0] F_DIV     = 6'h1A;
    localparam logic [5:0] F_DIVU    = 6'h1B;
    localparam logic [5:0] F_DMULT   = 6'h1C;
    localparam logic [5:0] F_DMULTU  = 6'h1D;
    localparam logic [5:0] F_DDIV    = 6'h1E;
    localparam logic [5:0] F_DDIVU   = 6'h1F;
    localparam logic [5:0] F_ADD     = 6'h20;
    localparam logic [5:0] F_ADDU    = 6'h21;
    localparam logic [5:0] F_SUB     = 6'h22;
    localparam logic [5:0] F_SUBU    = 6'h23;
    localparam logic [5:0] F_AND     = 6'h24;
    localparam logic [5:0] F_OR      = 6'h25;
    localparam logic [5:0] F_XOR     = 6'h26;
    localparam logic [5:0] F_NOR     = 6'h27;
    localparam logic [5:0] F_SLT     = 6'h2A;
    localparam logic [5:0] F_SLTU    = 6'h2B;
    localparam logic [5:0] F_DADD    = 6'h2C;
    localparam logic [5:0] F_DADDU   = 6'h2D;
    localparam logic [5:0] F_DSUB    = 6'h2E;
    localparam logic [5:0] F_DSUBU   = 6'h2F;
    localparam logic [5:0] F_DSLL    = 6'h38;
    localparam logic [5:0] F_DSRL    = 6'h3A;
    localparam logic [5:0] F_DSRA    = 6'h3B;
    localparam logic [5:0] F_DSLL32  = 6'h3C;
    localparam logic [5:0] F_DSRL32  = 6'h3E;
    localparam logic [5:0] F_DSRA32  = 6'h3F;

    // Exception codes
    localparam logic [2:0] EXC_NONE     = 3'd0;
    localparam logic [2:0] EXC_OVERFLOW = 3'd1;
    localparam logic [2:0] EXC_SYSCALL  = 3'd2;
    localparam logic [2:0] EXC_BREAK    = 3'd3;
    localparam logic [2:0] EXC_UNKNOWN  = 3'd4;

    localparam int MUL_STEPS = 4;   // 32x32 partial products
    localparam int DIV_STEPS = 64;  // one quotient bit per cycle

    // Controller commands to the datapath
    typedef struct packed {
        logic load;      // capture the item
        logic mul_step;  // accumulate one partial product
        logic div_step;  // retire one quotient bit
        logic finish;    // form the result, update HI/LO
    } t_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
    } t_status;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

@@ sv/mseu_ctrl.sv @@
// ----------------------------------------------------------------------------
// mseu_ctrl
// Sequencer: accepts an item, runs multiply or divide steps if needed, hands out result.
// ----------------------------------------------------------------------------
module mseu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  mseu_pkg::t_status   i_status,
    output mseu_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    logic in_fire;
    assign in_fire     = i_in_valid && o_in_ready;
    // accept a new item when idle and the output slot is free or being drained
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_cnt = '0;
                priority if (i_status.is_mul) begin
                    n_state = S_MUL;
                end else if (i_status.is_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 7'd1;
                if (r_cnt == 7'(mseu_pkg::MUL_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 7'd1;
                if (r_cnt == 7'(mseu_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ sv/mseu_dp.sv @@
// ----------------------------------------------------------------------------
// mseu_dp
// Datapath: operand capture, ALU and shifts, multiply and divide, HI/LO.
// ----------------------------------------------------------------------------
module mseu_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mseu_pkg::t_cmd    i_cmd,
    output mseu_pkg::t_status o_status,
    input  logic [5:0]        i_operation,
    input  logic [63:0]       i_rs_value,
    input  logic [63:0]       i_rt_value,
    input  logic [4:0]        i_shift_amount,
    input  logic [4:0]        i_dest_index,
    input  logic [63:0]       i_link_address,
    input  logic              i_in_exception_level,
    output logic [63:0]       o_result_value,
    output logic              o_write_enable,
    output logic [4:0]        o_dest_index_out,
    output logic              o_jump_taken,
    output logic [63:0]       o_jump_target,
    output logic              o_jump_is_call,
    output logic [2:0]        o_exception_code
);

    // captured item
    logic [5:0]  r_op;
    logic [63:0] r_rs, r_rt, r_link;
    logic [4:0]  r_sa, r_rd;
    logic        r_exl;

    // architectural state
    logic [63:0] r_hi, r_lo;

    // multiply / divide working registers
    logic [127:0] r_acc;
    logic [63:0]  r_ma, r_mb;      // multiply operands; r_mb also holds the divisor
    logic [1:0]   r_mstep;
    logic [63:0]  r_quo, r_rem;
    logic         r_neg_q, r_neg_r;

    // registered output
    logic [63:0] r_res, r_tgt;
    logic        r_we, r_jmp, r_call;
    logic [2:0]  r_exc;
    logic [4:0]  r_rd_out;

    logic is_word_mul, is_dmul, is_word_div, is_ddiv, is_signed_div;
    assign is_word_mul   = (r_op == mseu_pkg::F_MULT) || (r_op == mseu_pkg::F_MULTU);
    assign is_dmul       = (r_op == mseu_pkg::F_DMULT) || (r_op == mseu_pkg::F_DMULTU);
    assign is_word_div   = (r_op == mseu_pkg::F_DIV) || (r_op == mseu_pkg::F_DIVU);
    assign is_ddiv       = (r_op == mseu_pkg::F_DDIV) || (r_op == mseu_pkg::F_DDIVU);
    assign is_signed_div = (r_op == mseu_pkg::F_DIV) || (r_op == mseu_pkg::F_DDIV);

    assign o_status.is_mul = is_word_mul || is_dmul;
    assign o_status.is_div = is_word_div || is_ddiv;

    // divide operands, sign-corrected to magnitudes
    logic [63:0] dv_a, dv_b, mag_a, mag_b;
    logic        na, nb;
    always_comb begin
        if (is_word_div) begin
            dv_a = (r_op == mseu_pkg::F_DIV) ? mseu_pkg::sext32(r_rs[31:0])
                                             : {32'd0, r_rs[31:0]};
            dv_b = (r_op == mseu_pkg::F_DIV) ? mseu_pkg::sext32(r_rt[31:0])
                                             : {32'd0, r_rt[31:0]};
        end else begin
            dv_a = r_rs;
            dv_b = r_rt;
        end
        na    = is_signed_div && dv_a[63];
        nb    = is_signed_div && dv_b[63];
        mag_a = na ? (~dv_a + 64'd1) : dv_a;
        mag_b = nb ? (~dv_b + 64'd1) : dv_b;
    end

    // one restoring-divide step
    logic [64:0] rem_sh, rem_sub;
    assign rem_sh  = {r_rem, r_quo[63]};
    assign rem_sub = rem_sh - {1'b0, r_mb};

    // one 32x32 partial product, selected by step
    logic [31:0] pa, pb;
    logic [63:0] pp;
    logic [6:0]  pp_sh;
    assign pa    = r_mstep[0] ? r_ma[63:32] : r_ma[31:0];
    assign pb    = r_mstep[1] ? r_mb[63:32] : r_mb[31:0];
    assign pp    = {32'd0, pa} * {32'd0, pb};
    assign pp_sh = {1'b0, r_mstep[0] ^ 1'b0, 5'd0} + {1'b0, r_mstep[1], 5'd0};

    // final shifts and ALU
    logic [63:0] sres, adds, subs, w_sum, w_dif, sh_src;
    logic        word_ovf_add, word_ovf_sub, d_ovf_add, d_ovf_sub;
    logic [5:0]  shamt;
    always_comb begin
        adds         = r_rs + r_rt;
        subs         = r_rs - r_rt;
        w_sum        = {32'd0, r_rs[31:0] + r_rt[31:0]};
        w_dif        = {32'd0, r_rs[31:0] - r_rt[31:0]};
        word_ovf_add = (r_rs[31] ^ w_sum[31]) & (r_rt[31] ^ w_sum[31]);
        word_ovf_sub = (r_rs[31] ^ r_rt[31]) & (r_rs[31] ^ w_dif[31]);
        d_ovf_add    = (r_rs[63] ^ adds[63]) & (r_rt[63] ^ adds[63]);
        d_ovf_sub    = (r_rs[63] ^ r_rt[63]) & (r_rs[63] ^ subs[63]);
        sh_src       = r_rt;
        shamt        = {1'b0, r_sa};
        if (r_op == mseu_pkg::F_SLLV || r_op == mseu_pkg::F_SRLV
            || r_op == mseu_pkg::F_SRAV) begin
            shamt = {1'b0, r_rs[4:0]};
        end else if (r_op == mseu_pkg::F_DSLLV || r_op == mseu_pkg::F_DSRLV
            || r_op == mseu_pkg::F_DSRAV) begin
            shamt = r_rs[5:0];
        end else if (r_op == mseu_pkg::F_DSLL32 || r_op == mseu_pkg::F_DSRL32
            || r_op == mseu_pkg::F_DSRA32) begin
            shamt = {1'b1, r_sa};
        end
        if (r_op == mseu_pkg::F_SLL || r_op == mseu_pkg::F_SRL
            || r_op == mseu_pkg::F_SLLV || r_op == mseu_pkg::F_SRLV) begin
            sh_src = {32'd0, r_rt[31:0]};
        end
        sres = '0;
        unique case (r_op)
            mseu_pkg::F_SLL, mseu_pkg::F_SLLV, mseu_pkg::F_DSLL,
            mseu_pkg::F_DSLLV, mseu_pkg::F_DSLL32: sres = sh_src << shamt;
            mseu_pkg::F_SRA, mseu_pkg::F_SRAV, mseu_pkg::F_DSRA,
            mseu_pkg::F_DSRAV, mseu_pkg::F_DSRA32:
                sres = 64'($signed(sh_src) >>> shamt);
            default: sres = sh_src >> shamt;
        endcase
    end

    // form the result item
    logic [63:0] f_res, f_tgt, f_hi, f_lo, q_fix, r_fix, dmh;
    logic        f_we, f_jmp, f_call;
    logic [2:0]  f_exc;
    always_comb begin
        f_res = '0; f_we = 1'b0; f_jmp = 1'b0; f_call = 1'b0; f_tgt = '0;
        f_exc = mseu_pkg::EXC_NONE; f_hi = r_hi; f_lo = r_lo;
        q_fix = r_neg_q ? (~r_quo + 64'd1) : r_quo;
        r_fix = r_neg_r ? (~r_rem + 64'd1) : r_rem;
        dmh   = r_acc[127:64];
        if (r_op == mseu_pkg::F_DMULT) begin
            dmh = r_acc[127:64] - (r_rs[63] ? r_rt : 64'd0)
                  - (r_rt[63] ? r_rs : 64'd0);
        end
        unique case (r_op)
            mseu_pkg::F_SLL, mseu_pkg::F_SRL, mseu_pkg::F_SRA,
            mseu_pkg::F_SLLV, mseu_pkg::F_SRLV, mseu_pkg::F_SRAV: begin
                f_res = mseu_pkg::sext32(sres[31:0]); f_we = 1'b1;
            end
            mseu_pkg::F_DSLL, mseu_pkg::F_DSRL, mseu_pkg::F_DSRA,
            mseu_pkg::F_DSLLV, mseu_pkg::F_DSRLV, mseu_pkg::F_DSRAV,
            mseu_pkg::F_DSLL32, mseu_pkg::F_DSRL32, mseu_pkg::F_DSRA32: begin
                f_res = sres; f_we = 1'b1;
            end
            mseu_pkg::F_JR: begin
                f_jmp = 1'b1; f_tgt = r_rs;
            end
            mseu_pkg::F_JALR: begin
                f_jmp = 1'b1; f_call = 1'b1; f_tgt = r_rs; f_res = r_link; f_we = 1'b1;
            end
            mseu_pkg::F_SYSCALL: f_exc = mseu_pkg::EXC_SYSCALL;
            mseu_pkg::F_BREAK: if (!r_exl) f_exc = mseu_pkg::EXC_BREAK;
            mseu_pkg::F_SYNC: f_exc = mseu_pkg::EXC_NONE;
            mseu_pkg::F_MFHI: begin f_res = r_hi; f_we = 1'b1; end
            mseu_pkg::F_MTHI: f_hi = r_rs;
            mseu_pkg::F_MFLO: begin f_res = r_lo; f_we = 1'b1; end
            mseu_pkg::F_MTLO: f_lo = r_rs;
            mseu_pkg::F_MULT, mseu_pkg::F_MULTU: begin
                f_lo = mseu_pkg::sext32(r_acc[31:0]);
                f_hi = mseu_pkg::sext32(r_acc[63:32]);
            end
            mseu_pkg::F_DMULT, mseu_pkg::F_DMULTU: begin
                f_lo = r_acc[63:0]; f_hi = dmh;
            end
            mseu_pkg::F_DIV, mseu_pkg::F_DIVU: begin
                if (r_rt[31:0] == 32'd0) begin
                    f_hi = mseu_pkg::sext32(r_rs[31:0]);
                    f_lo = (r_op == mseu_pkg::F_DIV && r_rs[31]) ? 64'd1 : '1;
                end else begin
                    f_lo = mseu_pkg::sext32(q_fix[31:0]);
                    f_hi = mseu_pkg::sext32(r_fix[31:0]);
                end
            end
            mseu_pkg::F_DDIV, mseu_pkg::F_DDIVU: begin
                if (r_rt == 64'd0) begin
                    f_hi = r_rs;
                    f_lo = (r_op == mseu_pkg::F_DDIV && r_rs[63]) ? 64'd1 : '1;
                end else begin
                    f_lo = q_fix; f_hi = r_fix;
                end
            end
            mseu_pkg::F_ADD: begin
                if (word_ovf_add) f_exc = mseu_pkg::EXC_OVERFLOW;
                else begin f_res = mseu_pkg::sext32(w_sum[31:0]); f_we = 1'b1; end
            end
            mseu_pkg::F_ADDU: begin f_res = mseu_pkg::sext32(w_sum[31:0]); f_we = 1'b1; end
            mseu_pkg::F_SUB: begin
                if (word_ovf_sub) f_exc = mseu_pkg::EXC_OVERFLOW;
                else begin f_res = mseu_pkg::sext32(w_dif[31:0]); f_we = 1'b1; end
            end
            mseu_pkg::F_SUBU: begin f_res = mseu_pkg::sext32(w_dif[31:0]); f_we = 1'b1; end
            mseu_pkg::F_AND: begin f_res = r_rs & r_rt; f_we = 1'b1; end
            mseu_pkg::F_OR:  begin f_res = r_rs | r_rt; f_we = 1'b1; end
            mseu_pkg::F_XOR: begin f_res = r_rs ^ r_rt; f_we = 1'b1; end
            mseu_pkg::F_NOR: begin f_res = ~(r_rs | r_rt); f_we = 1'b1; end
            mseu_pkg::F_SLT: begin
                f_res = {63'd0, $signed(r_rs) < $signed(r_rt)}; f_we = 1'b1;
            end
            mseu_pkg::F_SLTU: begin f_res = {63'd0, r_rs < r_rt}; f_we = 1'b1; end
            mseu_pkg::F_DADD: begin
                if (d_ovf_add) f_exc = mseu_pkg::EXC_OVERFLOW;
                else begin f_res = adds; f_we = 1'b1; end
            end
            mseu_pkg::F_DADDU: begin f_res = adds; f_we = 1'b1; end
            mseu_pkg::F_DSUB: begin
                if (d_ovf_sub) f_exc = mseu_pkg::EXC_OVERFLOW;
                else begin f_res = subs; f_we = 1'b1; end
            end
            mseu_pkg::F_DSUBU: begin f_res = subs; f_we = 1'b1; end
            default: f_exc = mseu_pkg::EXC_UNKNOWN;
        endcase
    end

    // capture, iterate and finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (i_cmd.finish) begin
            r_hi <= f_hi;
            r_lo <= f_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation; r_rs <= i_rs_value; r_rt <= i_rt_value;
            r_sa <= i_shift_amount; r_rd <= i_dest_index;
            r_link <= i_link_address; r_exl <= i_in_exception_level;
        end
        // set up multiply or divide while decoding
        if (!i_cmd.load && !i_cmd.mul_step && !i_cmd.div_step && !i_cmd.finish) begin
            r_acc   <= '0;
            r_mstep <= '0;
            if (is_word_mul) begin
                r_ma <= (r_op == mseu_pkg::F_MULT) ? mseu_pkg::sext32(r_rs[31:0])
                                                   : {32'd0, r_rs[31:0]};
                r_mb <= (r_op == mseu_pkg::F_MULT) ? mseu_pkg::sext32(r_rt[31:0])
                                                   : {32'd0, r_rt[31:0]};
            end else if (is_dmul) begin
                r_ma <= r_rs;
                r_mb <= r_rt;
            end else begin
                r_mb <= mag_b;
            end
            r_quo   <= mag_a;
            r_rem   <= '0;
            r_neg_q <= na ^ nb;
            r_neg_r <= na;
        end
        if (i_cmd.mul_step) begin
            r_acc   <= r_acc + ({64'd0, pp} << pp_sh);
            r_mstep <= r_mstep + 2'd1;
        end
        if (i_cmd.div_step) begin
            if (!rem_sub[64]) begin
                r_rem <= rem_sub[63:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh[63:0];
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_res <= f_res; r_we <= f_we; r_jmp <= f_jmp; r_call <= f_call;
            r_tgt <= f_tgt; r_exc <= f_exc; r_rd_out <= r_rd;
        end
    end

    assign o_result_value   = r_res;
    assign o_write_enable   = r_we;
    assign o_dest_index_out = r_rd_out;
    assign o_jump_taken     = r_jmp;
    assign o_jump_target    = r_tgt;
    assign o_jump_is_call   = r_call;
    assign o_exception_code = r_exc;

endmodule

@@ sv/mips64_special_execute_unit.sv @@
// Executes one MIPS64 SPECIAL instruction per transfer and keeps HI and LO.
// Simple operations pass through decode and finish to the result; multiplies
// add four 32x32 partial products through one multiplier, and divides run
// a restoring divider at one quotient bit per cycle. One item is in
// work at a time; the next is taken no earlier than the cycle in which the
// last result transfers.
// ----------------------------------------------------------------------------
// mips64_special_execute_unit
// Top level: stream ports, sequencer and datapath.
// ----------------------------------------------------------------------------
module mips64_special_execute_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[5:0], rs_value[69:6], rt_value[133:70], shift_amount[138:134],
    // dest_index[143:139], link_address[207:144], in_exception_level[208], 0
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value[63:0], write_enable[64], dest_index_out[69:65],
    // jump_taken[70], jump_target[134:71], jump_is_call[135],
    // exception_code[138:136], 0
    output logic [143:0] m_axis_tdata
);

    mseu_pkg::t_cmd    cmd;
    mseu_pkg::t_status status;
    logic [63:0] res, tgt;
    logic        we, jmp, call;
    logic [4:0]  rd;
    logic [2:0]  exc;

    mseu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mseu_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_operation          (s_axis_tdata[5:0]),
        .i_rs_value           (s_axis_tdata[69:6]),
        .i_rt_value           (s_axis_tdata[133:70]),
        .i_shift_amount       (s_axis_tdata[138:134]),
        .i_dest_index         (s_axis_tdata[143:139]),
        .i_link_address       (s_axis_tdata[207:144]),
        .i_in_exception_level (s_axis_tdata[208]),
        .o_result_value       (res),
        .o_write_enable       (we),
        .o_dest_index_out     (rd),
        .o_jump_taken         (jmp),
        .o_jump_target        (tgt),
        .o_jump_is_call       (call),
        .o_exception_code     (exc)
    );

    assign m_axis_tdata = {5'd0, exc, call, tgt, jmp, rd, we, res};

endmodule
